// ===== rtl/bmp24_pkg.sv =====
`default_nettype none

package bmp24_pkg;

  // Header layout of a 24-bit BMP file (byte positions from the start mark).
  localparam int unsigned HDR_LEN    = 54;
  localparam int unsigned OFS_POS    = 10;
  localparam int unsigned WID_POS    = 18;
  localparam int unsigned HGT_POS    = 22;
  localparam int unsigned BPP_POS    = 28;
  localparam int unsigned DEPTH_24   = 24;

  // Header dimensions are held in 13 bits and saturate.
  localparam int unsigned DIM_W      = 13;
  localparam logic [DIM_W-1:0] DIM_SAT = 13'd8191;

  localparam int unsigned IDX_W      = 24;
  localparam int unsigned COUNT_W    = 32;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HEADER,
    PH_SKIP,
    PH_PIXEL,
    PH_PAD,
    PH_DONE,
    PH_ERROR
  } phase_t;

  typedef enum logic [1:0] {
    MODE_BW    = 2'd0,
    MODE_GRAY  = 2'd1,
    MODE_COLOR = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ERR_NONE   = 2'd0,
    ERR_DEPTH  = 2'd1,
    ERR_SIZE   = 2'd2,
    ERR_OFFSET = 2'd3
  } err_t;

  typedef struct packed {
    logic [IDX_W-1:0] pixel_index;
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic [7:0]       gray_level;
    logic             black_white;
    logic             last_pixel;
    err_t             error_code;
  } result_t;

  // Folds one little-endian byte into a saturating 13-bit dimension.
  function automatic logic [DIM_W-1:0] dim_take(logic [DIM_W-1:0] cur,
                                                logic [1:0] pos,
                                                logic [7:0] b);
    logic [DIM_W-1:0] res;
    res = cur;
    if (pos == 2'd0) begin
      res = DIM_W'(b);
    end else if (pos == 2'd1) begin
      if (b[7:5] != 3'd0) begin
        res = DIM_SAT;
      end else begin
        res = {b[4:0], cur[7:0]};
      end
    end else if (b != 8'd0) begin
      res = DIM_SAT;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/bmp24_pixel_stream_reader_top.sv =====
// A result is registered when the byte that completes it is accepted; one file byte per
// cycle while in_stall is low. The parser, the 12x13 index multiplier and the
// divide-by-three share one register stage, and a two-entry output queue absorbs stalls.
// Reset (rst_n low, synchronous): parser idle until a start mark, mode set to colour,
// output queue empty.
`default_nettype none

module bmp24_pixel_stream_reader_top
  import bmp24_pkg::*;
#(
  parameter int unsigned MAX_DIM = 4096
) (
  input  wire logic             clk,
  input  wire logic             rst_n,

  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [1:0]       cfg_image_mode,

  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [7:0]       in_data_byte,
  input  wire logic             in_start_of_file,

  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic [IDX_W-1:0]      out_pixel_index,
  output logic [7:0]            out_red,
  output logic [7:0]            out_green,
  output logic [7:0]            out_blue,
  output logic [7:0]            out_gray_level,
  output logic                  out_black_white,
  output logic                  out_last_pixel,
  output logic [1:0]            out_error_code
);

  localparam int unsigned POS_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int unsigned PROD_W = POS_W + DIM_W;

  // Parser state.
  phase_t               phase_r,  phase_nxt;
  logic [COUNT_W-1:0]   count_r,  count_nxt;
  logic [DIM_W-1:0]     width_r,  width_nxt;
  logic [DIM_W-1:0]     height_r, height_nxt;
  logic [COUNT_W-1:0]   offset_r, offset_nxt;
  logic [7:0]           depth_r,  depth_nxt;
  logic [POS_W-1:0]     column_r, column_nxt;
  logic [POS_W-1:0]     row_r,    row_nxt;
  logic [1:0]           pad_r,    pad_nxt;
  logic [1:0]           bip_r,    bip_nxt;
  logic [15:0]          held_r,   held_nxt;
  logic [1:0]           mode_r;

  // State as seen by the current byte: a start mark restarts parsing first.
  phase_t               c_phase;
  logic [COUNT_W-1:0]   c_count;
  logic [DIM_W-1:0]     c_width;
  logic [DIM_W-1:0]     c_height;
  logic [COUNT_W-1:0]   c_offset;
  logic [7:0]           c_depth;
  logic [POS_W-1:0]     c_column;
  logic [POS_W-1:0]     c_row;
  logic [1:0]           c_pad;
  logic [1:0]           c_bip;
  logic [15:0]          c_held;

  logic                 in_acc;
  logic [COUNT_W-1:0]   cnt_inc;
  logic [1:0]           pad_dec;
  logic                 row_end;
  logic                 last;
  logic [POS_W-1:0]     rows_from_top;
  logic [PROD_W-1:0]    row_base;
  logic [9:0]           color_sum;
  logic [19:0]          sum_scaled;
  logic [7:0]           avg;
  err_t                 hdr_err;

  logic                 res_pixel;
  logic                 res_error;
  result_t              res;

  // Output queue: main register plus one skid entry.
  result_t              out_r,    skid_r;
  logic                 out_valid_r, skid_valid_r;
  logic                 out_pop;

  assign in_acc    = in_valid && !in_stall;
  assign in_stall  = skid_valid_r;
  assign cfg_ready = 1'b1;

  // Restart view of the parser state.
  always_comb begin
    if (in_start_of_file) begin
      c_phase  = PH_HEADER;
      c_count  = '0;
      c_width  = '0;
      c_height = '0;
      c_offset = '0;
      c_depth  = '0;
      c_column = '0;
      c_row    = '0;
      c_pad    = '0;
      c_bip    = '0;
      c_held   = '0;
    end else begin
      c_phase  = phase_r;
      c_count  = count_r;
      c_width  = width_r;
      c_height = height_r;
      c_offset = offset_r;
      c_depth  = depth_r;
      c_column = column_r;
      c_row    = row_r;
      c_pad    = pad_r;
      c_bip    = bip_r;
      c_held   = held_r;
    end
  end

  // Shared arithmetic for the current byte.
  assign cnt_inc  = (c_count == '1) ? c_count : c_count + COUNT_W'(1);
  assign pad_dec  = c_pad - 2'd1;
  assign row_end  = (DIM_W'(c_column) + DIM_W'(1)) >= c_width;
  assign last     = row_end && ((DIM_W'(c_row) + DIM_W'(1)) >= c_height);

  assign rows_from_top = POS_W'(c_height - DIM_W'(1) - DIM_W'(c_row));
  assign row_base      = PROD_W'(rows_from_top) * PROD_W'(c_width);

  // The sum stays below 1536, where multiplying by 683/2048 floors exactly like /3.
  assign color_sum  = 10'(c_held[7:0]) + 10'(c_held[15:8]) + 10'(in_data_byte);
  assign sum_scaled = 20'(color_sum) * 20'd683;
  assign avg        = sum_scaled[18:11];

  // Header checks, in priority order.
  always_comb begin
    if (c_depth != 8'(DEPTH_24)) begin
      hdr_err = ERR_DEPTH;
    end else if (c_width > DIM_W'(MAX_DIM) || c_height > DIM_W'(MAX_DIM)) begin
      hdr_err = ERR_SIZE;
    end else if (c_offset < COUNT_W'(HDR_LEN)) begin
      hdr_err = ERR_OFFSET;
    end else begin
      hdr_err = ERR_NONE;
    end
  end

  // Next state of the parser.
  always_comb begin
    phase_nxt  = c_phase;
    count_nxt  = c_count;
    width_nxt  = c_width;
    height_nxt = c_height;
    offset_nxt = c_offset;
    depth_nxt  = c_depth;
    column_nxt = c_column;
    row_nxt    = c_row;
    pad_nxt    = c_pad;
    bip_nxt    = c_bip;
    held_nxt   = c_held;

    unique case (c_phase) inside
      PH_HEADER: begin
        count_nxt = cnt_inc;
        if (c_count >= COUNT_W'(OFS_POS) && c_count <= COUNT_W'(OFS_POS + 3)) begin
          offset_nxt = c_offset | (COUNT_W'(in_data_byte) << {(c_count[1:0] - 2'd2), 3'd0});
        end else if (c_count >= COUNT_W'(WID_POS) && c_count <= COUNT_W'(WID_POS + 3)) begin
          width_nxt = dim_take(c_width, c_count[1:0] - 2'd2, in_data_byte);
        end else if (c_count >= COUNT_W'(HGT_POS) && c_count <= COUNT_W'(HGT_POS + 3)) begin
          height_nxt = dim_take(c_height, c_count[1:0] - 2'd2, in_data_byte);
        end else if (c_count == COUNT_W'(BPP_POS)) begin
          depth_nxt = in_data_byte;
        end
        if (c_count == COUNT_W'(HDR_LEN - 1)) begin
          if (hdr_err != ERR_NONE) begin
            phase_nxt = PH_ERROR;
          end else if (c_width == '0 || c_height == '0) begin
            phase_nxt = PH_DONE;
          end else if (c_offset == COUNT_W'(HDR_LEN)) begin
            phase_nxt = PH_PIXEL;
          end else begin
            phase_nxt = PH_SKIP;
          end
        end
      end
      PH_SKIP: begin
        count_nxt = cnt_inc;
        if (cnt_inc >= c_offset) begin
          phase_nxt = PH_PIXEL;
        end
      end
      PH_PAD: begin
        count_nxt = cnt_inc;
        pad_nxt   = pad_dec;
        if (pad_dec == 2'd0) begin
          phase_nxt = PH_PIXEL;
        end
      end
      PH_PIXEL: begin
        count_nxt = cnt_inc;
        if (c_bip == 2'd0) begin
          held_nxt = {8'd0, in_data_byte};
          bip_nxt  = 2'd1;
        end else if (c_bip == 2'd1) begin
          held_nxt = {in_data_byte, c_held[7:0]};
          bip_nxt  = 2'd2;
        end else begin
          held_nxt = '0;
          bip_nxt  = 2'd0;
          if (last) begin
            phase_nxt = PH_DONE;
          end else if (row_end) begin
            column_nxt = '0;
            row_nxt    = c_row + POS_W'(1);
            pad_nxt    = c_width[1:0];
            if (c_width[1:0] != 2'd0) begin
              phase_nxt = PH_PAD;
            end
          end else begin
            column_nxt = c_column + POS_W'(1);
          end
        end
      end
      PH_IDLE, PH_DONE, PH_ERROR: begin
        phase_nxt = c_phase;
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  // Result for the current byte.
  always_comb begin
    res_pixel = (c_phase == PH_PIXEL) && (c_bip == 2'd2);
    res_error = (c_phase == PH_HEADER) && (c_count == COUNT_W'(HDR_LEN - 1)) &&
                (hdr_err != ERR_NONE);
    res       = '0;
    if (res_error) begin
      res.error_code = hdr_err;
    end else begin
      res.pixel_index = IDX_W'(row_base) + IDX_W'(c_column);
      res.last_pixel  = last;
      case (mode_r)
        MODE_COLOR: begin
          res.red   = in_data_byte;
          res.green = c_held[15:8];
          res.blue  = c_held[7:0];
        end
        MODE_GRAY: res.gray_level  = avg;
        MODE_BW:   res.black_white = avg[7];
        default:   res.last_pixel  = last;
      endcase
    end
  end

  // Parser registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      count_r  <= '0;
      width_r  <= '0;
      height_r <= '0;
      offset_r <= '0;
      depth_r  <= '0;
      column_r <= '0;
      row_r    <= '0;
      pad_r    <= '0;
      bip_r    <= '0;
      held_r   <= '0;
    end else if (in_acc) begin
      phase_r  <= phase_nxt;
      count_r  <= count_nxt;
      width_r  <= width_nxt;
      height_r <= height_nxt;
      offset_r <= offset_nxt;
      depth_r  <= depth_nxt;
      column_r <= column_nxt;
      row_r    <= row_nxt;
      pad_r    <= pad_nxt;
      bip_r    <= bip_nxt;
      held_r   <= held_nxt;
    end
  end

  // Mode register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_COLOR;
    end else if (cfg_valid && cfg_ready) begin
      mode_r <= cfg_image_mode;
    end
  end

  // Output queue control.
  assign out_pop = out_valid_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_pop) begin
        skid_valid_r <= 1'b0;
      end
    end else if (in_acc && (res_pixel || res_error)) begin
      if (!out_valid_r || out_pop) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (out_pop) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output queue data.
  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_pop) begin
        out_r <= skid_r;
      end
    end else if (in_acc && (res_pixel || res_error)) begin
      if (!out_valid_r || out_pop) begin
        out_r <= res;
      end else begin
        skid_r <= res;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_index = out_r.pixel_index;
  assign out_red         = out_r.red;
  assign out_green       = out_r.green;
  assign out_blue        = out_r.blue;
  assign out_gray_level  = out_r.gray_level;
  assign out_black_white = out_r.black_white;
  assign out_last_pixel  = out_r.last_pixel;
  assign out_error_code  = out_r.error_code;

endmodule

`default_nettype wire
